FILE: rtl/hep_pkg.sv
// shared types and constants for the huffman code packer
// no dependencies; used by every module of the block
`default_nettype none

package hep_pkg;

  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int SYMBOL_COUNT_DEF  = 256;

  localparam int SYMBOL_W    = 8;
  localparam int CODE_WORD_W = 32;
  localparam int CODE_LEN_W  = 6;
  localparam int BYTE_W      = 8;
  localparam int PEND_W      = 7;
  localparam int PCNT_W      = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [SYMBOL_W-1:0]      symbol;
    logic [CODE_WORD_W-1:0]   code_word;
    logic [CODE_LEN_W-1:0]    code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  // lookup stage to pack stage
  typedef struct packed {
    logic valid;
    logic encode;
    logic flush;
  } pack_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/hep_code_table.sv
// code table: load path (saturate, mask, bit reverse) and registered lookup
// depends on hep_pkg
`default_nettype none

module hep_code_table #(
  parameter int CODE_BITS    = hep_pkg::MAX_CODE_BITS_DEF,
  parameter int SYMBOL_COUNT = hep_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire hep_pkg::in_item_t              in_item,
  input  wire logic                           accept,
  input  wire logic                           adv,
  output hep_pkg::pack_ctl_t                  ctl_r,
  output logic [CODE_BITS-1:0]                code_r,
  output logic [hep_pkg::CODE_LEN_W-1:0]      len_r
);

  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W = CODE_BITS + hep_pkg::CODE_LEN_W;

  logic [ENTRY_W-1:0]                 table_mem [SYMBOL_COUNT];
  logic [ENTRY_W-1:0]                 rd_r;
  logic [IDX_W-1:0]                   idx;
  logic                               in_range;
  logic [hep_pkg::CODE_LEN_W-1:0]     len_sat;
  logic [CODE_BITS-1:0]               masked;
  logic [CODE_BITS-1:0]               rev_full;
  logic [CODE_BITS-1:0]               rev_al;
  hep_pkg::pack_ctl_t                 ctl_nxt;

  assign idx      = in_item.symbol[IDX_W-1:0];
  assign in_range = ({1'b0, in_item.symbol} < 9'(SYMBOL_COUNT));
  assign len_sat  = (in_item.code_length > hep_pkg::CODE_LEN_W'(CODE_BITS)) ?
                    hep_pkg::CODE_LEN_W'(CODE_BITS) : in_item.code_length;

  // drop bits at or above the length, then mirror so the first code bit
  // lands in bit 0
  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      masked[i] = in_item.code_word[i] & (hep_pkg::CODE_LEN_W'(i) < len_sat);
    end
    for (int i = 0; i < CODE_BITS; i++) begin
      rev_full[i] = masked[CODE_BITS-1-i];
    end
    rev_al = rev_full >> (hep_pkg::CODE_LEN_W'(CODE_BITS) - len_sat);
  end

  always_ff @(posedge clk) begin
    if (accept && (in_item.opcode == hep_pkg::OP_LOAD) && in_range) begin
      table_mem[idx] <= {len_sat, rev_al};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= table_mem[idx];
    end
  end

  assign len_r  = rd_r[ENTRY_W-1:CODE_BITS];
  assign code_r = rd_r[CODE_BITS-1:0];

  always_comb begin
    ctl_nxt = ctl_r;
    if (adv) begin
      ctl_nxt = '0;
    end
    if (accept) begin
      ctl_nxt.encode = (in_item.opcode == hep_pkg::OP_ENCODE) && in_range;
      ctl_nxt.flush  = (in_item.opcode == hep_pkg::OP_FLUSH);
      ctl_nxt.valid  = ctl_nxt.encode || ctl_nxt.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hep_packer.sv
// pack stage: merges a looked-up code with the pending bits and splits off
// whole bytes; holds the pending partial byte. depends on hep_pkg
`default_nettype none

module hep_packer #(
  parameter int CODE_BITS = hep_pkg::MAX_CODE_BITS_DEF,
  parameter int BYTES_MAX = (CODE_BITS + hep_pkg::PEND_W) / hep_pkg::BYTE_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire hep_pkg::pack_ctl_t                ctl,
  input  wire logic [CODE_BITS-1:0]              code,
  input  wire logic [hep_pkg::CODE_LEN_W-1:0]    len,
  input  wire logic                              emit_free,
  output logic                                   adv,
  output logic                                   emit_load,
  output logic [$clog2(BYTES_MAX+1)-1:0]         emit_n,
  output logic [BYTES_MAX*hep_pkg::BYTE_W-1:0]   emit_data
);

  localparam int ACC_W = CODE_BITS + hep_pkg::PEND_W;
  localparam int TOT_W = $clog2(CODE_BITS + 8);
  localparam int NB_W  = $clog2(BYTES_MAX + 1);

  logic [hep_pkg::PEND_W-1:0]  pbits_r, pbits_nxt;
  logic [hep_pkg::PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [ACC_W-1:0]            acc;
  logic [ACC_W-1:0]            acc_rest;
  logic [TOT_W-1:0]            total;
  logic [NB_W-1:0]             nbytes;

  assign acc   = ACC_W'(pbits_r) | (ACC_W'(code) << pcnt_r);
  assign total = TOT_W'(pcnt_r) + TOT_W'(len);

  always_comb begin
    acc_rest  = '0;
    nbytes    = '0;
    emit_data = '0;
    pbits_nxt = pbits_r;
    pcnt_nxt  = pcnt_r;
    if (ctl.encode) begin
      nbytes    = NB_W'(total >> 3);
      emit_data = acc[BYTES_MAX*hep_pkg::BYTE_W-1:0];
      acc_rest  = acc >> {nbytes, 3'b000};
      pbits_nxt = acc_rest[hep_pkg::PEND_W-1:0];
      pcnt_nxt  = total[hep_pkg::PCNT_W-1:0];
    end else if (ctl.flush) begin
      // empty flush emits nothing
      nbytes    = (pcnt_r != '0) ? NB_W'(1) : '0;
      emit_data = (BYTES_MAX*hep_pkg::BYTE_W)'(pbits_r);
      pbits_nxt = '0;
      pcnt_nxt  = '0;
    end
    adv       = ctl.valid && ((nbytes == '0) || emit_free);
    emit_load = adv && (nbytes != '0);
    emit_n    = nbytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r <= '0;
      pcnt_r  <= '0;
    end else if (adv) begin
      pbits_r <= pbits_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hep_byte_out.sv
// output register: holds the bytes of one item and hands them out one per
// beat, marking the final one. depends on hep_pkg
`default_nettype none

module hep_byte_out #(
  parameter int BYTES_MAX = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  emit_load,
  input  wire logic [$clog2(BYTES_MAX+1)-1:0]        emit_n,
  input  wire logic [BYTES_MAX*hep_pkg::BYTE_W-1:0]  emit_data,
  output logic                                       emit_free,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output hep_pkg::out_item_t                         out_item
);

  localparam int NB_W   = $clog2(BYTES_MAX + 1);
  localparam int DATA_W = BYTES_MAX * hep_pkg::BYTE_W;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic [NB_W-1:0]   cnt_r, cnt_nxt;
  logic              take;

  assign out_valid         = (cnt_r != '0);
  assign take              = out_valid && !out_stall;
  assign emit_free         = (cnt_r == '0) || ((cnt_r == NB_W'(1)) && take);
  assign out_item.out_byte = data_r[hep_pkg::BYTE_W-1:0];
  assign out_item.last     = (cnt_r == NB_W'(1));

  always_comb begin
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    if (emit_load) begin
      data_nxt = emit_data;
      cnt_nxt  = emit_n;
    end else if (take) begin
      data_nxt = data_r >> hep_pkg::BYTE_W;
      cnt_nxt  = cnt_r - NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/huffman_encoder_bit_packer.sv
// huffman code packer, top level; uses hep_pkg, hep_code_table, hep_packer,
// hep_byte_out
// an encode or flush passes the lookup and output registers before its first
// byte is valid; throughput: one item per cycle while the pack stage can
// hand its bytes on; an item's bytes go out one by one, up to 4 for 32-bit codes
// reset clears pending bits and pipeline valids; the table is not cleared
`default_nettype none

module huffman_encoder_bit_packer #(
  parameter int MAX_CODE_BITS = hep_pkg::MAX_CODE_BITS_DEF,
  parameter int SYMBOL_COUNT  = hep_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hep_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hep_pkg::out_item_t       out_item
);

  localparam int CODE_BITS = (MAX_CODE_BITS < hep_pkg::CODE_WORD_W) ?
                             MAX_CODE_BITS : hep_pkg::CODE_WORD_W;
  localparam int BYTES_MAX = (CODE_BITS + hep_pkg::PEND_W) / hep_pkg::BYTE_W;
  localparam int NB_W      = $clog2(BYTES_MAX + 1);

  hep_pkg::pack_ctl_t                 ctl;
  logic [CODE_BITS-1:0]               code;
  logic [hep_pkg::CODE_LEN_W-1:0]     len;
  logic                               accept;
  logic                               adv;
  logic                               emit_free;
  logic                               emit_load;
  logic [NB_W-1:0]                    emit_n;
  logic [BYTES_MAX*hep_pkg::BYTE_W-1:0] emit_data;

  // lookup stage holds when the pack stage cannot hand its bytes on
  assign in_stall = ctl.valid && !adv;
  assign accept   = in_valid && !in_stall;

  hep_code_table #(
    .CODE_BITS    (CODE_BITS),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .accept  (accept),
    .adv     (adv),
    .ctl_r   (ctl),
    .code_r  (code),
    .len_r   (len)
  );

  hep_packer #(
    .CODE_BITS (CODE_BITS),
    .BYTES_MAX (BYTES_MAX)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .code      (code),
    .len       (len),
    .emit_free (emit_free),
    .adv       (adv),
    .emit_load (emit_load),
    .emit_n    (emit_n),
    .emit_data (emit_data)
  );

  hep_byte_out #(
    .BYTES_MAX (BYTES_MAX)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_load (emit_load),
    .emit_n    (emit_n),
    .emit_data (emit_data),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for huffman_encoder_bit_packer: code table loads,
// symbol encodes, flushes and unused opcodes, checked against a packed-byte predictor
// depends on hep_pkg and the huffman_encoder_bit_packer top level

module testbench;
  import hep_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 8;
  localparam int CODE_CAP     = (MAX_CODE_BITS_DEF < CODE_WORD_W) ? MAX_CODE_BITS_DEF
                                                                  : CODE_WORD_W;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // predictor state
  logic [CODE_WORD_W-1:0] code_tbl [SYMBOL_COUNT_DEF];
  logic [CODE_LEN_W-1:0]  len_tbl  [SYMBOL_COUNT_DEF];
  logic [PEND_W-1:0]      pend_bits = '0;
  logic [PCNT_W-1:0]      pend_cnt = '0;
  out_item_t              expected_bytes [$];

  // stimulus bookkeeping
  bit                  sym_loaded [SYMBOL_COUNT_DEF];
  logic [SYMBOL_W-1:0] loaded_syms [$];
  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int bytes_checked = 0;
  int n_load, n_encode, n_flush, n_unused;
  int quiet_cycles = 0;

  huffman_encoder_bit_packer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [CODE_WORD_W-1:0] mirror_code(input logic [CODE_WORD_W-1:0] code,
                                                        input int len);
    logic [CODE_WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < len; i++) r[len-1-i] = code[i];
    return r;
  endfunction

  task automatic predict_packed_bytes(input in_item_t it);
    int          len;
    int          total;
    logic [63:0] acc;
    out_item_t   b;
    case (it.opcode)
      OP_LOAD: begin
        len = int'(it.code_length);
        if (len > CODE_CAP) len = CODE_CAP;
        code_tbl[it.symbol] = CODE_WORD_W'({32'd0, it.code_word} & ((64'd1 << len) - 64'd1));
        len_tbl[it.symbol]  = CODE_LEN_W'(len);
      end
      OP_ENCODE: begin
        len = int'(len_tbl[it.symbol]);
        if (len != 0) begin
          acc = {57'd0, pend_bits} |
                ({32'd0, mirror_code(code_tbl[it.symbol], len)} << pend_cnt);
          total = int'(pend_cnt) + len;
          while (total >= 8) begin
            b.out_byte = acc[7:0];
            // final byte of this item when fewer than 8 bits remain after it
            b.last = (total < 16);
            expected_bytes.push_back(b);
            acc = acc >> 8;
            total -= 8;
          end
          pend_bits = acc[PEND_W-1:0];
          pend_cnt  = PCNT_W'(total);
        end
      end
      OP_FLUSH: begin
        if (pend_cnt != 0) begin
          b.out_byte = {1'b0, pend_bits};
          b.last     = 1'b1;
          expected_bytes.push_back(b);
        end
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_error($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report_error($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.last !== want.last)
        report_error($sformatf("last %0b, expected %0b (byte %02h)",
                               got.last, want.last, want.out_byte));
    end
    bytes_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_packed_bytes(in_item);
      if (out_valid && !out_stall) check_byte(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no beat for %0d cycles, %0d bytes outstanding",
                   quiet_cycles, expected_bytes.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input opcode_t op, input logic [SYMBOL_W-1:0] sym,
                           input logic [CODE_WORD_W-1:0] word,
                           input logic [CODE_LEN_W-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid              = 1'b1;
    in_item.opcode        = op;
    in_item.symbol        = sym;
    in_item.code_word     = word;
    in_item.code_length   = len;
    case (op)
      OP_LOAD: begin
        n_load++;
        if (!sym_loaded[sym]) begin
          sym_loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      OP_ENCODE: n_encode++;
      OP_FLUSH:  n_flush++;
      default:   n_unused++;
    endcase
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  function automatic logic [CODE_LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 70) return CODE_LEN_W'($urandom_range(12, 1));
    if (r < 90) return CODE_LEN_W'($urandom_range(32, 13));
    return CODE_LEN_W'($urandom_range(63, 33));
  endfunction

  task automatic test_directed_cases();
    send_item(OP_LOAD, 8'h00, 32'h0000_0001, 6'd1);
    send_item(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_item(OP_LOAD, 8'hAA, 32'h0000_1234, 6'd0);   // zero length
    send_item(OP_LOAD, 8'h55, 32'hA5A5_5A5A, 6'd63);  // saturates to the cap
    send_item(OP_LOAD, 8'h0F, 32'hFFFF_FFF5, 6'd3);   // upper code bits dropped
    send_item(OP_LOAD, 8'h33, 32'h0000_0096, 6'd8);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);          // nothing pending
    send_item(OP_ENCODE, 8'h33, 32'h0, 6'd0);         // exactly one aligned byte
    send_item(OP_ENCODE, 8'h0F, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);         // 35 bits, four bytes
    send_item(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_item(opcode_t'(OP_UNUSED), 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    repeat (5) send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      // hold off mid-phase until the output side has caught up
      if (i == count / 2) wait_drained();
      r = $urandom_range(99);
      if (r < 15 || loaded_syms.size() == 0)
        send_item(OP_LOAD, SYMBOL_W'($urandom_range(255)), $urandom(), pick_length());
      else if (r < 85)
        send_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                  $urandom(), CODE_LEN_W'($urandom_range(63)));
      else if (r < 95)
        send_item(OP_FLUSH, SYMBOL_W'($urandom_range(255)), $urandom(),
                  CODE_LEN_W'($urandom_range(63)));
      else
        send_item(opcode_t'(OP_UNUSED), SYMBOL_W'($urandom_range(255)), $urandom(),
                  CODE_LEN_W'($urandom_range(63)));
    end
    wait_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    send_idle_pct = 26;
    recv_idle_pct = 84;
    n_load = 0; n_encode = 0; n_flush = 0; n_unused = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_traffic(103, 26, 84);
    test_random_traffic(103, 84, 26);
    test_random_traffic(104, 0, 0);

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d beats: %0d loads, %0d encodes, %0d flushes, %0d unused opcodes",
             n_load + n_encode + n_flush + n_unused, n_load, n_encode, n_flush, n_unused);
    $display("checked %0d packed bytes with %0d table entries in use, %0d errors",
             bytes_checked, loaded_syms.size(), errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
